>>> hdl/pcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg
// shared types, constants and the arctangent table of the converter
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam logic MODE_CART  = 1'b0;
  localparam logic MODE_POLAR = 1'b1;

  // inverse cordic gain, q30
  localparam logic [29:0] INVK_Q30 = 30'd652032874;

  // angle accumulator units are pi/2^31
  localparam logic signed [31:0] Z_QUARTER = 32'sh4000_0000;
  localparam logic [31:0]        Z_HALF    = 32'h8000_0000;

  // output angle units are pi/32768
  localparam logic signed [16:0] ANG_PI          = 17'sd32768;
  localparam logic signed [16:0] ANG_HALF_PI     = 17'sd16384;
  localparam logic signed [16:0] ANG_NEG_HALF_PI = -17'sd16384;

  typedef struct packed {
    logic              valid;
    logic              mode;
    logic              spec;
    logic              xneg;
    logic              yneg;
    logic signed [5:0] sh;
  } ctl_t;

  function automatic logic signed [31:0] atan_entry(input int idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sh20000000;
      1:  v = 32'sh12E4051E;
      2:  v = 32'sh09FB385B;
      3:  v = 32'sh051111D4;
      4:  v = 32'sh028B0D43;
      5:  v = 32'sh0145D7E1;
      6:  v = 32'sh00A2F61E;
      7:  v = 32'sh00517C55;
      8:  v = 32'sh0028BE53;
      9:  v = 32'sh00145F2F;
      10: v = 32'sh000A2F98;
      11: v = 32'sh000517CC;
      12: v = 32'sh00028BE6;
      13: v = 32'sh000145F3;
      14: v = 32'sh0000A2FA;
      15: v = 32'sh0000517D;
      16: v = 32'sh000028BE;
      17: v = 32'sh0000145F;
      18: v = 32'sh00000A30;
      19: v = 32'sh00000518;
      20: v = 32'sh0000028C;
      21: v = 32'sh00000146;
      22: v = 32'sh000000A3;
      23: v = 32'sh00000051;
      24: v = 32'sh00000029;
      25: v = 32'sh00000014;
      26: v = 32'sh0000000A;
      27: v = 32'sh00000005;
      28: v = 32'sh00000003;
      29: v = 32'sh00000001;
      30: v = 32'sh00000001;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/polar_cartesian_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polar_cartesian_converter
// pipelined cordic converter, polar to cartesian and cartesian to polar
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_mode, in_coord_a, in_coord_b
// out      output     out_valid / out_stall  out_result_a, out_result_b
//
// one transaction per cycle sustained while in_stall is low; the chain has
// two input stages, one cell per micro-rotation and two output stages
// the whole chain advances together; in_stall is high only while a
// result waits at the output and out_stall is high
// reset clears the valid bits of every stage
// ----------------------------------------------------------------------------
module polar_cartesian_converter #(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_coord_a,
  input  logic signed [COORD_WIDTH:0]   in_coord_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH:0]   out_result_a,
  output logic signed [COORD_WIDTH:0]   out_result_b
);

  localparam int XW = (COORD_WIDTH + 18 > 34) ? COORD_WIDTH + 18 : 34;

  logic                 en;
  pcc_pkg::ctl_t        ctl_w [0:ITERATIONS];
  logic signed [XW-1:0] x_w   [0:ITERATIONS];
  logic signed [XW-1:0] y_w   [0:ITERATIONS];
  logic signed [31:0]   z_w   [0:ITERATIONS];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  pcc_pre #(
    .COORD_WIDTH(COORD_WIDTH),
    .XW         (XW)
  ) u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_coord_a(in_coord_a),
    .in_coord_b(in_coord_b),
    .ctl_o     (ctl_w[0]),
    .x_o       (x_w[0]),
    .y_o       (y_w[0]),
    .z_o       (z_w[0])
  );

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    pcc_cell #(
      .XW   (XW),
      .SHIFT(g)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .ctl_i(ctl_w[g]),
      .x_i  (x_w[g]),
      .y_i  (y_w[g]),
      .z_i  (z_w[g]),
      .ctl_o(ctl_w[g+1]),
      .x_o  (x_w[g+1]),
      .y_o  (y_w[g+1]),
      .z_o  (z_w[g+1])
    );
  end

  pcc_post #(
    .COORD_WIDTH(COORD_WIDTH),
    .XW         (XW)
  ) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .ctl_i       (ctl_w[ITERATIONS]),
    .x_i         (x_w[ITERATIONS]),
    .y_i         (y_w[ITERATIONS]),
    .z_i         (z_w[ITERATIONS]),
    .out_valid   (out_valid),
    .out_result_a(out_result_a),
    .out_result_b(out_result_b)
  );

endmodule
`default_nettype wire

>>> hdl/pcc_pre.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pre
// two input stages: gain scaling and quadrant fold for polar input,
// magnitude, special cases and normalization for cartesian input
// ----------------------------------------------------------------------------
module pcc_pre #(
  parameter int COORD_WIDTH = 16,
  parameter int XW          = 34
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_coord_a,
  input  logic signed [COORD_WIDTH:0]   in_coord_b,
  output pcc_pkg::ctl_t                 ctl_o,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o,
  output logic signed [31:0]            z_o
);

  localparam int W    = COORD_WIDTH;
  localparam int PW   = W + 31;
  localparam int MSBW = $clog2(W + 1);

  // stage a
  logic signed [30:0]   invk_s;
  logic signed [W:0]    a_ext;
  logic signed [W+16:0] b_ext;
  pcc_pkg::ctl_t        a_ctl_nxt, a_ctl_r;
  logic signed [PW-1:0] a_prod_nxt, a_prod_r;
  logic [W:0]           a_ax_nxt, a_ax_r;
  logic [W:0]           a_ay_nxt, a_ay_r;
  logic                 a_xzero_r, a_yzero_r;
  logic [15:0]          a_ang_r;

  assign invk_s = {1'b0, pcc_pkg::INVK_Q30};
  assign a_ext  = (W+1)'(in_coord_a);
  assign b_ext  = (W+17)'(in_coord_b);

  always_comb begin
    a_ctl_nxt       = '0;
    a_ctl_nxt.valid = in_valid;
    a_ctl_nxt.mode  = in_mode;
    a_ctl_nxt.xneg  = in_coord_a[W-1];
    a_ctl_nxt.yneg  = in_coord_b[W];
    a_prod_nxt      = PW'(in_coord_a) * PW'(invk_s);
    a_ax_nxt        = in_coord_a[W-1] ? $unsigned(-a_ext) : $unsigned(a_ext);
    a_ay_nxt        = in_coord_b[W] ? $unsigned(-in_coord_b) : $unsigned(in_coord_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else if (en) begin
      a_ctl_r <= a_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r  <= a_prod_nxt;
      a_ax_r    <= a_ax_nxt;
      a_ay_r    <= a_ay_nxt;
      a_xzero_r <= (in_coord_a == '0);
      a_yzero_r <= (in_coord_b == '0);
      a_ang_r   <= b_ext[15:0];
    end
  end

  // stage b
  logic [W:0]           or_c;
  logic [MSBW-1:0]      msb_c;
  logic signed [5:0]    sh_c;
  logic [W+29:0]        nx_c, ny_c;
  logic signed [31:0]   z_t;
  logic signed [XW-1:0] x_t;
  pcc_pkg::ctl_t        ctl_nxt, ctl_r;
  logic signed [XW-1:0] x_nxt, x_r, y_nxt, y_r;
  logic signed [31:0]   z_nxt, z_r;

  assign or_c = a_ax_r | a_ay_r;

  always_comb begin
    msb_c = '0;
    for (int k = 0; k < W + 1; k++) begin
      if (or_c[k]) begin
        msb_c = MSBW'(k);
      end
    end
  end

  assign sh_c = 6'(29 - int'(msb_c));
  assign nx_c = {a_ax_r, 29'b0} >> msb_c;
  assign ny_c = {a_ay_r, 29'b0} >> msb_c;
  assign z_t  = {a_ang_r, 16'h0000};
  assign x_t  = XW'(a_prod_r >>> 14);

  always_comb begin
    ctl_nxt = a_ctl_r;
    x_nxt   = x_t;
    y_nxt   = '0;
    z_nxt   = z_t;
    if (a_ctl_r.mode == pcc_pkg::MODE_CART) begin
      if (z_t > pcc_pkg::Z_QUARTER) begin
        x_nxt = -x_t;
        z_nxt = z_t - pcc_pkg::Z_HALF;
      end else if (z_t < -pcc_pkg::Z_QUARTER) begin
        x_nxt = -x_t;
        z_nxt = z_t + pcc_pkg::Z_HALF;
      end
    end else if (a_yzero_r) begin
      ctl_nxt.spec = 1'b1;
      x_nxt        = XW'(a_ax_r);
      z_nxt        = a_ctl_r.xneg ? 32'(pcc_pkg::ANG_PI) : '0;
    end else if (a_xzero_r) begin
      ctl_nxt.spec = 1'b1;
      x_nxt        = a_ay_r[W] ? XW'({W{1'b1}}) : XW'(a_ay_r);
      z_nxt        = a_ctl_r.yneg ? 32'(pcc_pkg::ANG_NEG_HALF_PI)
                                  : 32'(pcc_pkg::ANG_HALF_PI);
    end else begin
      ctl_nxt.sh = sh_c;
      x_nxt      = XW'(nx_c[29:0]);
      y_nxt      = XW'(ny_c[29:0]);
      z_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule
`default_nettype wire

>>> hdl/pcc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_cell
// one cordic micro-rotation, rotation or vectoring by mode, registered
// ----------------------------------------------------------------------------
module pcc_cell #(
  parameter int XW    = 34,
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  pcc_pkg::ctl_t        ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [31:0]   z_i,
  output pcc_pkg::ctl_t        ctl_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [31:0]   z_o
);

  localparam logic signed [31:0] ATAN = pcc_pkg::atan_entry(SHIFT);

  logic signed [XW-1:0] dx, dy;
  logic                 ccw;
  pcc_pkg::ctl_t        ctl_r;
  logic signed [XW-1:0] x_nxt, x_r, y_nxt, y_r;
  logic signed [31:0]   z_nxt, z_r;

  assign dx  = y_i >>> SHIFT;
  assign dy  = x_i >>> SHIFT;
  assign ccw = (ctl_i.mode == pcc_pkg::MODE_CART) ? !z_i[31] : y_i[XW-1];

  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (!ctl_i.spec) begin
      if (ccw) begin
        x_nxt = x_i - dx;
        y_nxt = y_i + dy;
        z_nxt = z_i - ATAN;
      end else begin
        x_nxt = x_i + dx;
        y_nxt = y_i - dy;
        z_nxt = z_i + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule
`default_nettype wire

>>> hdl/pcc_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_post
// two output stages: rounding and saturation of coordinates, gain removal
// and rounding of the radius, angle quadrant mapping, output register
// ----------------------------------------------------------------------------
module pcc_post #(
  parameter int COORD_WIDTH = 16,
  parameter int XW          = 34
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  pcc_pkg::ctl_t               ctl_i,
  input  logic signed [XW-1:0]        x_i,
  input  logic signed [XW-1:0]        y_i,
  input  logic signed [31:0]          z_i,
  output logic                        out_valid,
  output logic signed [COORD_WIDTH:0] out_result_a,
  output logic signed [COORD_WIDTH:0] out_result_b
);

  localparam int W = COORD_WIDTH;
  localparam logic signed [XW-1:0] C_HI = XW'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [XW-1:0] C_LO = -C_HI - XW'(1);

  function automatic logic signed [W:0] sat_coord(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    s = (v + XW'(32768)) >>> 16;
    if (s > C_HI) begin
      return C_HI[W:0];
    end else if (s < C_LO) begin
      return C_LO[W:0];
    end
    return s[W:0];
  endfunction

  // stage p
  logic [31:0]        xc;
  logic signed [31:0] zs;
  logic               fin_nxt, fin_r;
  pcc_pkg::ctl_t      p_ctl_r;
  logic signed [W:0]  p_a_nxt, p_a_r, p_b_nxt, p_b_r;
  logic [61:0]        p_prod_nxt, p_prod_r;
  logic [14:0]        p_ang_nxt, p_ang_r;

  always_comb begin
    xc = x_i[XW-1] ? 32'd0 : x_i[31:0];
    if (z_i[31]) begin
      zs = '0;
    end else if (z_i > pcc_pkg::Z_QUARTER) begin
      zs = pcc_pkg::Z_QUARTER;
    end else begin
      zs = z_i;
    end
    p_prod_nxt = 62'(xc) * 62'(pcc_pkg::INVK_Q30);
    p_ang_nxt  = 15'((zs + 32'sd32768) >>> 16);
    fin_nxt    = (ctl_i.mode == pcc_pkg::MODE_CART) || ctl_i.spec;
    if (ctl_i.mode == pcc_pkg::MODE_CART) begin
      p_a_nxt = sat_coord(x_i);
      p_b_nxt = sat_coord(y_i);
    end else begin
      p_a_nxt = {1'b0, x_i[W-1:0]};
      p_b_nxt = (W+1)'(z_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r <= '0;
    end else if (en) begin
      p_ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r    <= fin_nxt;
      p_a_r    <= p_a_nxt;
      p_b_r    <= p_b_nxt;
      p_prod_r <= p_prod_nxt;
      p_ang_r  <= p_ang_nxt;
    end
  end

  // stage q
  logic [5:0]         tot_c;
  logic [62:0]        rnd_c, q_c;
  logic [W-1:0]       rad_c;
  logic signed [16:0] a17, ang_c;
  logic               valid_r;
  logic signed [W:0]  res_a_nxt, res_a_r, res_b_nxt, res_b_r;

  assign tot_c = 6'(30 + int'(p_ctl_r.sh));
  assign rnd_c = {1'b0, p_prod_r} + (63'd1 << (tot_c - 6'd1));
  assign q_c   = rnd_c >> tot_c;
  assign rad_c = (|q_c[62:W]) ? {W{1'b1}} : q_c[W-1:0];
  assign a17   = signed'({2'b00, p_ang_r});

  always_comb begin
    case ({p_ctl_r.xneg, p_ctl_r.yneg})
      2'b00:   ang_c = a17;
      2'b10:   ang_c = pcc_pkg::ANG_PI - a17;
      2'b11:   ang_c = pcc_pkg::ANG_PI + a17;
      default: ang_c = -a17;
    endcase
    if (fin_r) begin
      res_a_nxt = p_a_r;
      res_b_nxt = p_b_r;
    end else begin
      res_a_nxt = {1'b0, rad_c};
      res_b_nxt = (W+1)'(ang_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= p_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_a_r <= res_a_nxt;
      res_b_r <= res_b_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_result_a = res_a_r;
  assign out_result_b = res_b_r;

endmodule
`default_nettype wire
